[src/svlpf_pkg.sv]
// ---------------------------------------------------------------------------
// svlpf_pkg: shared types and constants for the servo long-packet framer
// Descriptor format between the front and back parts, header constants,
// register indexes and reset values.
// ---------------------------------------------------------------------------
package svlpf_pkg;

  localparam logic [7:0] HDR_FIRST  = 8'hFA;
  localparam logic [7:0] HDR_SECOND = 8'hAF;

  // Step index of the last header byte (motor count).
  localparam logic [2:0] HDR_LAST_STEP = 3'd6;

  localparam int DEF_MAX_MOTORS          = 16;
  localparam int DEF_MAX_BYTES_PER_MOTOR = 8;

  localparam int QUEUE_DEPTH = 4;

  // Configuration register indexes.
  localparam logic [7:0] CFG_REG_ADDRESS     = 8'd0;
  localparam logic [7:0] CFG_BYTES_PER_MOTOR = 8'd1;
  localparam logic [7:0] CFG_MOTOR_COUNT     = 8'd2;
  localparam logic [7:0] CFG_FIRST_ID        = 8'd3;

  localparam logic [7:0] RST_REG_ADDRESS     = 8'd30;
  localparam logic [3:0] RST_BYTES_PER_MOTOR = 4'd4;
  localparam logic [4:0] RST_MOTOR_COUNT     = 5'd5;
  localparam logic [7:0] RST_FIRST_ID        = 8'd1;

  localparam logic [0:0] CMD_BEGIN = 1'b0;
  localparam logic [0:0] CMD_DATA  = 1'b1;

  typedef enum logic [1:0] {
    DESC_HEADER,
    DESC_ERROR,
    DESC_DATA
  } desc_kind_t;

  // Header: b_a = register address, b_b = length, b_c = motor count.
  // Data:   b_a = motor ID, b_b = payload byte, b_c = checksum.
  typedef struct packed {
    desc_kind_t kind;
    logic       with_id;
    logic       with_csum;
    logic [7:0] b_a;
    logic [7:0] b_b;
    logic [7:0] b_c;
  } desc_t;

  typedef struct packed {
    logic push_ready;
    logic head_valid;
  } queue_status_t;

endpackage

[src/svlpf_front.sv]
// ---------------------------------------------------------------------------
// svlpf_front: command intake and packet bookkeeping
// Holds the configuration registers and the packet state, classifies each
// item and hands one descriptor per item to the queue.
// ---------------------------------------------------------------------------
module svlpf_front #(
  parameter int MAX_MOTORS          = svlpf_pkg::DEF_MAX_MOTORS,
  parameter int MAX_BYTES_PER_MOTOR = svlpf_pkg::DEF_MAX_BYTES_PER_MOTOR
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  input  logic               item_accept,
  input  logic               command,
  input  logic [7:0]         data_byte,
  output svlpf_pkg::desc_t   desc
);

  localparam int BpmCapInt = (MAX_BYTES_PER_MOTOR > 15) ? 15 : MAX_BYTES_PER_MOTOR;
  localparam int CntCapInt = (MAX_MOTORS > 31) ? 31 : MAX_MOTORS;
  localparam logic [3:0] BPM_CAP = 4'(BpmCapInt);
  localparam logic [4:0] CNT_CAP = 5'(CntCapInt);

  logic [7:0] reg_addr_r;
  logic [3:0] bpm_r;
  logic [4:0] cnt_r;
  logic [7:0] first_id_r;

  logic       open_r,      open_nxt;
  logic [4:0] motor_idx_r, motor_idx_nxt;
  logic [3:0] byte_idx_r,  byte_idx_nxt;
  logic [7:0] xor_r,       xor_nxt;

  logic [3:0] bpm_eff;
  logic [4:0] cnt_eff;
  logic [7:0] len_byte;
  logic [7:0] cnt_byte;
  logic [7:0] motor_id;
  logic [7:0] data_xor;
  logic       motor_end;
  logic       pkt_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reg_addr_r <= svlpf_pkg::RST_REG_ADDRESS;
      bpm_r      <= svlpf_pkg::RST_BYTES_PER_MOTOR;
      cnt_r      <= svlpf_pkg::RST_MOTOR_COUNT;
      first_id_r <= svlpf_pkg::RST_FIRST_ID;
    end else if (cfg_we) begin
      case (cfg_index)
        svlpf_pkg::CFG_REG_ADDRESS:     reg_addr_r <= cfg_data;
        svlpf_pkg::CFG_BYTES_PER_MOTOR: bpm_r      <= cfg_data[3:0];
        svlpf_pkg::CFG_MOTOR_COUNT:     cnt_r      <= cfg_data[4:0];
        svlpf_pkg::CFG_FIRST_ID:        first_id_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sizes are clamped into their legal ranges before use.
  always_comb begin
    if (bpm_r == 4'd0) bpm_eff = 4'd1;
    else if (bpm_r > BPM_CAP) bpm_eff = BPM_CAP;
    else bpm_eff = bpm_r;
    if (cnt_r == 5'd0) cnt_eff = 5'd1;
    else if (cnt_r > CNT_CAP) cnt_eff = CNT_CAP;
    else cnt_eff = cnt_r;
  end

  assign len_byte  = {4'd0, bpm_eff} + 8'd1;
  assign cnt_byte  = {3'd0, cnt_eff};
  assign motor_id  = first_id_r + {3'd0, motor_idx_r};
  assign data_xor  = xor_r ^ data_byte ^ ((byte_idx_r == 4'd0) ? motor_id : 8'd0);
  assign motor_end = ({1'b0, byte_idx_r} + 5'd1) >= {1'b0, bpm_eff};
  assign pkt_end   = ({1'b0, motor_idx_r} + 6'd1) >= {1'b0, cnt_eff};

  always_comb begin
    open_nxt      = open_r;
    motor_idx_nxt = motor_idx_r;
    byte_idx_nxt  = byte_idx_r;
    xor_nxt       = xor_r;
    desc.kind      = svlpf_pkg::DESC_ERROR;
    desc.with_id   = 1'b0;
    desc.with_csum = 1'b0;
    desc.b_a       = motor_id;
    desc.b_b       = data_byte;
    desc.b_c       = data_xor;
    if (command == svlpf_pkg::CMD_BEGIN) begin
      desc.kind     = svlpf_pkg::DESC_HEADER;
      desc.b_a      = reg_addr_r;
      desc.b_b      = len_byte;
      desc.b_c      = cnt_byte;
      open_nxt      = 1'b1;
      motor_idx_nxt = 5'd0;
      byte_idx_nxt  = 4'd0;
      xor_nxt       = reg_addr_r ^ len_byte ^ cnt_byte;
    end else if (open_r) begin
      desc.kind    = svlpf_pkg::DESC_DATA;
      desc.with_id = (byte_idx_r == 4'd0);
      xor_nxt      = data_xor;
      if (motor_end) begin
        byte_idx_nxt = 4'd0;
        if (pkt_end) begin
          desc.with_csum = 1'b1;
          open_nxt       = 1'b0;
          motor_idx_nxt  = 5'd0;
          xor_nxt        = 8'd0;
        end else begin
          motor_idx_nxt = motor_idx_r + 5'd1;
        end
      end else begin
        byte_idx_nxt = byte_idx_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r      <= 1'b0;
      motor_idx_r <= 5'd0;
      byte_idx_r  <= 4'd0;
      xor_r       <= 8'd0;
    end else if (item_accept) begin
      open_r      <= open_nxt;
      motor_idx_r <= motor_idx_nxt;
      byte_idx_r  <= byte_idx_nxt;
      xor_r       <= xor_nxt;
    end
  end

endmodule

[src/svlpf_queue.sv]
// ---------------------------------------------------------------------------
// svlpf_queue: descriptor queue
// Small first-in first-out buffer that decouples intake from byte output.
// ---------------------------------------------------------------------------
module svlpf_queue (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  svlpf_pkg::desc_t         push_desc,
  input  logic                     pop,
  output svlpf_pkg::desc_t         head_desc,
  output svlpf_pkg::queue_status_t status
);

  localparam int Depth = svlpf_pkg::QUEUE_DEPTH;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  svlpf_pkg::desc_t  mem_r [Depth];
  logic [PtrW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0]   count_r;

  assign status.push_ready = (count_r != CntW'(Depth));
  assign status.head_valid = (count_r != '0);
  assign head_desc         = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop) count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

endmodule

[src/svlpf_back.sv]
// ---------------------------------------------------------------------------
// svlpf_back: byte sequencer
// Walks the queue head to the output register one byte per unstalled cycle.
// ---------------------------------------------------------------------------
module svlpf_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             head_valid,
  input  svlpf_pkg::desc_t head_desc,
  output logic             pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_tdata,
  output logic             out_tlast,
  output logic             out_tuser
);

  logic [2:0] step_r;
  logic       valid_r;
  logic [7:0] byte_r;
  logic       last_r;
  logic       err_r;

  logic       load;
  logic [7:0] cur_byte;
  logic       cur_last;
  logic       cur_err;
  logic       cur_final;
  logic [1:0] slot;

  assign load = head_valid && (!valid_r || out_tready);
  assign pop  = load && cur_final;

  // Data slots: zero is the motor ID, one the payload byte, two the checksum.
  assign slot = head_desc.with_id ? step_r[1:0] : step_r[1:0] + 2'd1;

  always_comb begin
    cur_byte  = 8'd0;
    cur_last  = 1'b0;
    cur_err   = 1'b0;
    cur_final = 1'b1;
    case (head_desc.kind)
      svlpf_pkg::DESC_HEADER: begin
        cur_final = (step_r == svlpf_pkg::HDR_LAST_STEP);
        case (step_r)
          3'd0:    cur_byte = svlpf_pkg::HDR_FIRST;
          3'd1:    cur_byte = svlpf_pkg::HDR_SECOND;
          3'd4:    cur_byte = head_desc.b_a;
          3'd5:    cur_byte = head_desc.b_b;
          3'd6:    cur_byte = head_desc.b_c;
          default: cur_byte = 8'd0;
        endcase
      end
      svlpf_pkg::DESC_DATA: begin
        cur_final = (slot == (head_desc.with_csum ? 2'd2 : 2'd1));
        cur_last  = (slot == 2'd2);
        case (slot)
          2'd0:    cur_byte = head_desc.b_a;
          2'd1:    cur_byte = head_desc.b_b;
          default: cur_byte = head_desc.b_c;
        endcase
      end
      default: begin
        cur_last = 1'b1;
        cur_err  = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= 3'd0;
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
      step_r  <= cur_final ? 3'd0 : step_r + 3'd1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= cur_byte;
      last_r <= cur_last;
      err_r  <= cur_err;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = byte_r;
  assign out_tlast  = last_r;
  assign out_tuser  = err_r;

endmodule

[src/servo_long_packet_framer.sv]
// An accepted item passes through the descriptor queue and then the output
// register. Throughput: the output register sends one byte per cycle while
// out_tready is high; an item makes 1 byte for plain data or an error, 2 or 3
// at a motor or packet boundary, 7 for a begin. Intake runs ahead through a
// four-entry descriptor queue. Synchronous active-low reset clears packet
// state, the queue and the output, and restores the register defaults.
// ---------------------------------------------------------------------------
// servo_long_packet_framer: multi-servo write packet builder
// Turns begin and data commands into a header, ID-prefixed payload and an
// XOR checksum byte stream.
// ---------------------------------------------------------------------------
module servo_long_packet_framer #(
  parameter int MAX_MOTORS          = svlpf_pkg::DEF_MAX_MOTORS,
  parameter int MAX_BYTES_PER_MOTOR = svlpf_pkg::DEF_MAX_BYTES_PER_MOTOR
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tuser,   // [0] command
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast,
  output logic       out_tuser   // [0] error
);

  svlpf_pkg::desc_t         front_desc;
  svlpf_pkg::desc_t         head_desc;
  svlpf_pkg::queue_status_t q_status;
  logic                     in_accept;
  logic                     pop;

  assign cfg_ready = 1'b1;
  assign in_tready = q_status.push_ready;
  assign in_accept = in_tvalid && in_tready;

  svlpf_front #(
    .MAX_MOTORS          (MAX_MOTORS),
    .MAX_BYTES_PER_MOTOR (MAX_BYTES_PER_MOTOR)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .item_accept (in_accept),
    .command     (in_tuser),
    .data_byte   (in_tdata),
    .desc        (front_desc)
  );

  svlpf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_accept),
    .push_desc (front_desc),
    .pop       (pop),
    .head_desc (head_desc),
    .status    (q_status)
  );

  svlpf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_status.head_valid),
    .head_desc  (head_desc),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  // An error result is a single zero byte that closes its run.
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && out_tdata == 8'd0)
    else $error("error result without last or with nonzero byte");

  // With nothing queued the intake must be open.
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !q_status.head_valid |-> in_tready)
    else $error("intake stalled while queue empty");

  // The sequencer only advances through a queued descriptor.
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_status.head_valid)
    else $error("pop from empty queue");

  // A begin queued into an empty pipeline shows its first header byte once it
  // has passed the queue and the output register.
  a_hdr_first: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_tuser == svlpf_pkg::CMD_BEGIN && !q_status.head_valid && !out_tvalid
    |=> ##1 out_tvalid && out_tdata == svlpf_pkg::HDR_FIRST)
    else $error("header did not start with the first sync byte");

endmodule
